// ----- rtl/gcb_pkg.sv -----
// ----------------------------------------------------------------------------
// Grapheme cluster boundary package
// Shared types, code point constants and class ranges for the cluster
// boundary flagger.
// ----------------------------------------------------------------------------
package gcb_pkg;

  // A decoded Unicode scalar value; values above 0x10FFFF pass as ordinary.
  localparam int unsigned CpWidth = 21;
  typedef logic [CpWidth-1:0] cp_t;

  // Single code points with a rule of their own.
  localparam cp_t CpCr  = 21'h0000D;
  localparam cp_t CpLf  = 21'h0000A;
  localparam cp_t CpZwj = 21'h0200D;

  // Extender ranges: combining marks, variation selectors and skin tones.
  localparam cp_t ExtCombLo   = 21'h00300;
  localparam cp_t ExtCombHi   = 21'h0036F;
  localparam cp_t ExtCombExLo = 21'h01AB0;
  localparam cp_t ExtCombExHi = 21'h01AFF;
  localparam cp_t ExtCombSuLo = 21'h01DC0;
  localparam cp_t ExtCombSuHi = 21'h01DFF;
  localparam cp_t ExtSymLo    = 21'h020D0;
  localparam cp_t ExtSymHi    = 21'h020FF;
  localparam cp_t ExtHalfLo   = 21'h0FE20;
  localparam cp_t ExtHalfHi   = 21'h0FE2F;
  localparam cp_t ExtVsLo     = 21'h0FE00;
  localparam cp_t ExtVsHi     = 21'h0FE0F;
  localparam cp_t ExtVsSupLo  = 21'hE0100;
  localparam cp_t ExtVsSupHi  = 21'hE01EF;
  localparam cp_t ExtToneLo   = 21'h1F3FB;
  localparam cp_t ExtToneHi   = 21'h1F3FF;

  // Regional indicator symbols.
  localparam cp_t RiLo = 21'h1F1E6;
  localparam cp_t RiHi = 21'h1F1FF;

  // Regional indicator count of the open cluster.
  typedef logic [1:0] flag_count_t;
  localparam flag_count_t FlagNone = 2'd0;
  localparam flag_count_t FlagOne  = 2'd1;
  localparam flag_count_t FlagPair = 2'd2;

  // Character class of one code point.
  typedef struct packed {
    logic is_cr;
    logic is_lf;
    logic is_zwj;
    logic is_ext;
    logic is_ri;
  } cp_class_t;

endpackage

// ----- rtl/gcb_if.sv -----
// ----------------------------------------------------------------------------
// Grapheme cluster boundary channels
// Valid/ready channels for input code points and for boundary results.
// ----------------------------------------------------------------------------
interface gcb_item_if;
  logic            valid;
  logic            ready;
  gcb_pkg::cp_t    codepoint;
  logic            text_start;
  logic            last_of_text;

  modport source (output valid, output codepoint, output text_start,
                  output last_of_text, input ready);
  modport sink   (input valid, input codepoint, input text_start,
                  input last_of_text, output ready);
endinterface

interface gcb_result_if;
  logic            valid;
  logic            ready;
  logic            starts_cluster;
  gcb_pkg::cp_t    codepoint_out;

  modport source (output valid, output starts_cluster, output codepoint_out,
                  input ready);
  modport sink   (input valid, input starts_cluster, input codepoint_out,
                  output ready);
endinterface

// ----- rtl/grapheme_cluster_boundary.sv -----
// ----------------------------------------------------------------------------
// Grapheme cluster boundary flagger
// Flags each decoded code point that begins a new grapheme cluster.
// ----------------------------------------------------------------------------
// The block takes one code point per cycle while neither side stalls and
// returns, for every one, the code point itself with a flag that is high
// where a new grapheme cluster begins. Code points go through an input
// register and then a result register, where the result is presented until
// it is taken. The sustained rate is one code point per clock cycle when
// nothing stalls: the cluster state update is combinational range compares
// and flag logic. Both sides may stall at any time; the input is
// accepted whenever the input register is free or moves on in the same cycle.
// Setting text_start forces a new cluster, and all cluster state clears after
// a code point marked last_of_text.
module grapheme_cluster_boundary (
  input  logic                clk,
  input  logic                rst,
  gcb_item_if.sink            item,
  gcb_result_if.source        result
);

  logic                 hold_valid;
  gcb_pkg::cp_t         hold_cp;
  logic                 hold_start;
  logic                 hold_last;

  logic                 res_valid;
  logic                 res_starts;
  gcb_pkg::cp_t         res_cp;

  logic                 res_free;
  logic                 step;
  gcb_pkg::cp_class_t   cls;
  logic                 starts;

  // Handshake: the result register frees when empty or being taken.
  assign res_free   = !res_valid || result.ready;
  assign step       = hold_valid && res_free;
  assign item.ready = !hold_valid || res_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item.ready) begin
      hold_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      hold_cp    <= item.codepoint;
      hold_start <= item.text_start;
      hold_last  <= item.last_of_text;
    end
  end

  gcb_classify u_classify (
    .codepoint (hold_cp),
    .cls       (cls)
  );

  gcb_state u_state (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .cls            (cls),
    .text_start     (hold_start),
    .last_of_text   (hold_last),
    .starts_cluster (starts)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_starts <= starts;
      res_cp     <= hold_cp;
    end
  end

  assign result.valid          = res_valid;
  assign result.starts_cluster = res_starts;
  assign result.codepoint_out  = res_cp;

endmodule

// ----- rtl/gcb_classify.sv -----
// ----------------------------------------------------------------------------
// Code point classifier
// Range compares that sort one code point into the classes the boundary
// rules care about.
// ----------------------------------------------------------------------------
module gcb_classify (
  input  gcb_pkg::cp_t      codepoint,
  output gcb_pkg::cp_class_t cls
);

  function automatic logic in_range(gcb_pkg::cp_t cp, gcb_pkg::cp_t lo,
                                    gcb_pkg::cp_t hi);
    return (cp >= lo) && (cp <= hi);
  endfunction

  // Each class is an independent set of compares against constants.
  always_comb begin
    cls.is_cr  = (codepoint == gcb_pkg::CpCr);
    cls.is_lf  = (codepoint == gcb_pkg::CpLf);
    cls.is_zwj = (codepoint == gcb_pkg::CpZwj);
    cls.is_ri  = in_range(codepoint, gcb_pkg::RiLo, gcb_pkg::RiHi);
    cls.is_ext = in_range(codepoint, gcb_pkg::ExtCombLo, gcb_pkg::ExtCombHi)
               | in_range(codepoint, gcb_pkg::ExtCombExLo, gcb_pkg::ExtCombExHi)
               | in_range(codepoint, gcb_pkg::ExtCombSuLo, gcb_pkg::ExtCombSuHi)
               | in_range(codepoint, gcb_pkg::ExtSymLo, gcb_pkg::ExtSymHi)
               | in_range(codepoint, gcb_pkg::ExtHalfLo, gcb_pkg::ExtHalfHi)
               | in_range(codepoint, gcb_pkg::ExtVsLo, gcb_pkg::ExtVsHi)
               | in_range(codepoint, gcb_pkg::ExtVsSupLo, gcb_pkg::ExtVsSupHi)
               | in_range(codepoint, gcb_pkg::ExtToneLo, gcb_pkg::ExtToneHi);
  end

endmodule

// ----- rtl/gcb_state.sv -----
// ----------------------------------------------------------------------------
// Cluster state and boundary decision
// Holds the state of the open cluster and decides, for the code point in
// the input register, whether it begins a new cluster.
// ----------------------------------------------------------------------------
module gcb_state (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  gcb_pkg::cp_class_t cls,
  input  logic               text_start,
  input  logic               last_of_text,
  output logic               starts_cluster
);

  logic                 cluster_open;
  logic                 cr_only;
  logic                 cluster_closed;
  gcb_pkg::flag_count_t flag_count;
  logic                 joiner_pending;

  logic                 cluster_open_next;
  logic                 cr_only_next;
  logic                 cluster_closed_next;
  gcb_pkg::flag_count_t flag_count_next;
  logic                 joiner_pending_next;

  // The join rules in priority order, then the state of a new cluster.
  always_comb begin
    logic starts;
    cluster_open_next   = cluster_open;
    cr_only_next        = cr_only;
    cluster_closed_next = cluster_closed;
    flag_count_next     = flag_count;
    joiner_pending_next = joiner_pending;

    if (text_start || !cluster_open || cluster_closed) begin
      starts = 1'b1;
    end else if (cr_only) begin
      // Only LF may follow a lone CR, and then the cluster is complete.
      if (cls.is_lf) begin
        starts              = 1'b0;
        cr_only_next        = 1'b0;
        cluster_closed_next = 1'b1;
      end else begin
        starts = 1'b1;
      end
    end else if (joiner_pending) begin
      starts              = 1'b0;
      joiner_pending_next = 1'b0;
    end else if (cls.is_ext) begin
      starts = 1'b0;
    end else if (cls.is_zwj) begin
      starts              = 1'b0;
      joiner_pending_next = 1'b1;
    end else if (flag_count == gcb_pkg::FlagOne && cls.is_ri) begin
      starts          = 1'b0;
      flag_count_next = gcb_pkg::FlagPair;
    end else begin
      starts = 1'b1;
    end

    if (starts) begin
      cluster_open_next   = 1'b1;
      cr_only_next        = cls.is_cr;
      cluster_closed_next = cls.is_lf;
      flag_count_next     = cls.is_ri ? gcb_pkg::FlagOne : gcb_pkg::FlagNone;
      joiner_pending_next = 1'b0;
    end

    // The end of a text drops all cluster state.
    if (last_of_text) begin
      cluster_open_next   = 1'b0;
      cr_only_next        = 1'b0;
      cluster_closed_next = 1'b0;
      flag_count_next     = gcb_pkg::FlagNone;
      joiner_pending_next = 1'b0;
    end

    starts_cluster = starts;
  end

  // State advances once for each code point that moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_open   <= 1'b0;
      cr_only        <= 1'b0;
      cluster_closed <= 1'b0;
      flag_count     <= gcb_pkg::FlagNone;
      joiner_pending <= 1'b0;
    end else if (step) begin
      cluster_open   <= cluster_open_next;
      cr_only        <= cr_only_next;
      cluster_closed <= cluster_closed_next;
      flag_count     <= flag_count_next;
      joiner_pending <= joiner_pending_next;
    end
  end

  // A lone CR and a closed cluster are exclusive kinds of open cluster.
  a_kind_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cr_only && cluster_closed))
    else $error("cluster is both a lone CR and closed");

  // No cluster detail survives without an open cluster.
  a_detail_needs_open: assert property (@(posedge clk) disable iff (rst)
    (cr_only || cluster_closed || joiner_pending || flag_count != gcb_pkg::FlagNone)
      |-> cluster_open)
    else $error("cluster detail held with no cluster open");

  // A pending joiner only follows a ZWJ inside an ordinary cluster.
  a_joiner_ordinary: assert property (@(posedge clk) disable iff (rst)
    joiner_pending |-> !cr_only && !cluster_closed)
    else $error("joiner pending in a CR or LF cluster");

  // The flag count never reaches its unused code.
  a_flag_range: assert property (@(posedge clk) disable iff (rst)
    flag_count == gcb_pkg::FlagNone || flag_count == gcb_pkg::FlagOne ||
    flag_count == gcb_pkg::FlagPair)
    else $error("flag count out of range");

  // The last code point of a text leaves no cluster open.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    step && last_of_text |=> !cluster_open)
    else $error("cluster still open after end of text");

endmodule
